// File: sv/ase_pkg.sv
// Shared types and defaults for the insertion sort engine.
// Used by ase_cell and array_sort_engine; depends on nothing else.
`default_nettype none

package ase_pkg;

  localparam int unsigned DepthDef      = 64;
  localparam int unsigned ValueWidthDef = 16;

  typedef struct packed {
    logic insert;
    logic drain;
  } ase_ctrl_t;

endpackage

`default_nettype wire

// File: sv/array_sort_engine.sv
// Insertion sort engine: a chain of DEPTH cells kept in ascending order.
// Each accepted value is placed in order unless the last cell is full (then it is dropped);
// an accepted last value starts the drain. Results follow one per cycle, the first in the
// cycle after the last value is accepted, while busy is high; the receiver cannot stall.
// Reset empties every cell and ends any drain in progress.
// Depends on ase_pkg and ase_cell.
`default_nettype none

module array_sort_engine #(
  parameter int unsigned DEPTH       = ase_pkg::DepthDef,
  parameter int unsigned VALUE_WIDTH = ase_pkg::ValueWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [VALUE_WIDTH-1:0] value_i,
  input  wire logic                   is_last_i,
  output logic                        strobe_o,
  output logic [VALUE_WIDTH-1:0]      sorted_value_o,
  output logic                        end_of_set_o
);

  logic [VALUE_WIDTH-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]       cell_valid;
  logic [DEPTH-1:0]       cell_gt;

  ase_pkg::ase_ctrl_t ctrl;
  logic               accept;
  logic               draining_q, draining_d;

  assign accept      = start && !draining_q;
  assign ctrl.insert = accept && !cell_valid[DEPTH-1];
  assign ctrl.drain  = draining_q;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] prev_value, next_value;
    logic                   prev_valid, prev_gt, next_valid;

    if (i == 0) begin : g_head
      assign prev_value = '0;
      assign prev_valid = 1'b0;
      assign prev_gt    = 1'b0;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign prev_valid = cell_valid[i-1];
      assign prev_gt    = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_value = '0;
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_value = cell_value[i+1];
      assign next_valid = cell_valid[i+1];
    end

    ase_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_value_i (value_i),
      .prev_value_i(prev_value),
      .prev_valid_i(prev_valid),
      .prev_gt_i   (prev_gt),
      .next_value_i(next_value),
      .next_valid_i(next_valid),
      .value_o     (cell_value[i]),
      .valid_o     (cell_valid[i]),
      .gt_o        (cell_gt[i])
    );
  end

  always_comb begin
    draining_d = draining_q;
    if (accept && is_last_i) begin
      draining_d = 1'b1;
    end else if (draining_q && !cell_valid[1]) begin
      draining_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draining_q <= 1'b0;
    end else begin
      draining_q <= draining_d;
    end
  end

  assign busy           = draining_q;
  assign strobe_o       = draining_q;
  assign sorted_value_o = cell_value[0];
  assign end_of_set_o   = !cell_valid[1];

endmodule

`default_nettype wire

// File: sv/ase_cell.sv
// One cell of the sorted insertion chain: holds one value and its valid bit.
// Depends on ase_pkg for the control struct.
`default_nettype none

module ase_cell #(
  parameter int unsigned VALUE_WIDTH = ase_pkg::ValueWidthDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ase_pkg::ase_ctrl_t     ctrl_i,
  input  wire logic [VALUE_WIDTH-1:0] new_value_i,
  input  wire logic [VALUE_WIDTH-1:0] prev_value_i,
  input  wire logic                   prev_valid_i,
  input  wire logic                   prev_gt_i,
  input  wire logic [VALUE_WIDTH-1:0] next_value_i,
  input  wire logic                   next_valid_i,
  output logic [VALUE_WIDTH-1:0]      value_o,
  output logic                        valid_o,
  output logic                        gt_o
);

  logic [VALUE_WIDTH-1:0] value_q, value_d;
  logic                   valid_q, valid_d;

  // A cell is displaced when it is empty or holds a larger value.
  assign gt_o = !valid_q || (value_q > new_value_i);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (ctrl_i.insert && gt_o) begin
      if (prev_gt_i) begin
        value_d = prev_value_i;
        valid_d = prev_valid_i;
      end else begin
        value_d = new_value_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.drain) begin
      value_d = next_value_i;
      valid_d = next_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for array_sort_engine: a directed table, then random sets,
// checked beat by beat against an insertion-ordered prediction of each emitted set.
// Depends on ase_pkg and the array_sort_engine RTL.

module testbench;

  localparam int unsigned Depth      = ase_pkg::DepthDef;
  localparam int unsigned ValueWidth = ase_pkg::ValueWidthDef;
  localparam int unsigned ItemTarget = 420;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned DrainSlack = Depth + 16;
  localparam int unsigned DirRows    = 17;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic                  end_flag;
  } sorted_beat_t;

  typedef struct packed {
    logic [ValueWidth-1:0] value;
    logic                  last;
    logic                  typed;
    logic [ValueWidth-1:0] typed_value;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [ValueWidth-1:0] value_i;
  logic                  is_last_i;
  logic                  strobe_o;
  logic [ValueWidth-1:0] sorted_value_o;
  logic                  end_of_set_o;

  logic                  row_typed;
  logic [ValueWidth-1:0] row_typed_value;
  bit                    idle_enabled;
  bit                    in_beat_seen = 1'b0;
  int unsigned           quiet_cycles = 0;
  int unsigned           error_count  = 0;

  logic [ValueWidth-1:0] held_values[$];
  sorted_beat_t          emitted_now[$];
  sorted_beat_t          pending_results[$];

  // Single-value sets, among them the extremes, have their result typed in; the rest are predicted.
  dir_row_t dir_rows [DirRows] = '{
    '{16'h0000, 1'b1, 1'b1, 16'h0000},
    '{16'hffff, 1'b1, 1'b1, 16'hffff},
    '{16'hffff, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 1'b0, 16'h0000},
    '{16'h7fff, 1'b0, 1'b0, 16'h0000},
    '{16'h0001, 1'b0, 1'b0, 16'h0000},
    '{16'hfffe, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'haaaa, 1'b0, 1'b0, 16'h0000},
    '{16'h5555, 1'b1, 1'b0, 16'h0000},
    '{16'h002a, 1'b0, 1'b0, 16'h0000},
    '{16'h002a, 1'b0, 1'b0, 16'h0000},
    '{16'h002a, 1'b1, 1'b0, 16'h0000},
    '{16'h1234, 1'b0, 1'b0, 16'h0000},
    '{16'h0001, 1'b1, 1'b0, 16'h0000},
    '{16'ha5a5, 1'b1, 1'b1, 16'ha5a5}
  };

  array_sort_engine #(
    .DEPTH      (Depth),
    .VALUE_WIDTH(ValueWidth)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .value_i       (value_i),
    .is_last_i     (is_last_i),
    .strobe_o      (strobe_o),
    .sorted_value_o(sorted_value_o),
    .end_of_set_o  (end_of_set_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH at %0t: %s, expected %0h, got %0h", $time, what, want, got);
    error_count++;
  endtask

  // Keeps the held values in ascending order as they arrive; a last beat releases them.
  task automatic predict_sorted_set(input logic [ValueWidth-1:0] v, input logic last);
    int pos;
    emitted_now.delete();
    if (held_values.size() < Depth) begin
      pos = held_values.size();
      while (pos > 0 && held_values[pos-1] > v) pos--;
      held_values.insert(pos, v);
    end
    if (last) begin
      foreach (held_values[k]) begin
        emitted_now.push_back('{held_values[k], k == held_values.size() - 1});
      end
      held_values.delete();
    end
  endtask

  function automatic logic [ValueWidth-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return ValueWidth'($urandom_range(0, 7));
    if (roll < 35) return ($urandom_range(0, 1) == 0) ? '0 : '1;
    return ValueWidth'($urandom_range(0, 65535));
  endfunction

  always @(posedge clk_i) begin : monitor_p
    sorted_beat_t want;
    if (rst_ni) begin
      in_beat_seen = start && !busy;
      if (strobe_o) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", '0, 32'(sorted_value_o));
        end else begin
          want = pending_results.pop_front();
          if (sorted_value_o !== want.value) begin
            report_mismatch("sorted_value", 32'(want.value), 32'(sorted_value_o));
          end
          if (end_of_set_o !== want.end_flag) begin
            report_mismatch("end_of_set", 32'(want.end_flag), 32'(end_of_set_o));
          end
        end
      end
      if (in_beat_seen) begin
        predict_sorted_set(value_i, is_last_i);
        if (row_typed && is_last_i) begin
          pending_results.push_back('{row_typed_value, 1'b1});
        end else begin
          foreach (emitted_now[k]) pending_results.push_back(emitted_now[k]);
        end
      end
      if (in_beat_seen || strobe_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IdleLimit) begin
        $display("array_sort_engine test failed");
        $finish;
      end
    end
  end

  // Called and returning at a falling edge; the beat is held until the engine takes it.
  task automatic send_value(input logic [ValueWidth-1:0] v, input logic last,
                            input logic typed, input logic [ValueWidth-1:0] typed_v);
    while (idle_enabled && $urandom_range(0, 99) < 16) begin
      start     <= 1'b0;
      value_i   <= ValueWidth'($urandom_range(0, 65535));
      is_last_i <= 1'($urandom_range(0, 1));
      @(negedge clk_i);
    end
    start           <= 1'b1;
    value_i         <= v;
    is_last_i       <= last;
    row_typed       <= typed;
    row_typed_value <= typed_v;
    do @(negedge clk_i); while (!in_beat_seen);
  endtask

  initial begin : stimulus_p
    int unsigned set_count;
    int unsigned stored_items;
    int unsigned set_len;
    int unsigned roll;
    set_count       = 0;
    stored_items    = 0;
    rst_ni          = 1'b0;
    start           = 1'b0;
    value_i         = '0;
    is_last_i       = 1'b0;
    row_typed       = 1'b0;
    row_typed_value = '0;
    idle_enabled    = 1'b1;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      send_value(dir_rows[r].value, dir_rows[r].last, dir_rows[r].typed,
                 dir_rows[r].typed_value);
    end

    // The first random sets fill the store exactly, then overrun it.
    while (stored_items < ItemTarget) begin
      roll = $urandom_range(0, 99);
      if (set_count == 0) set_len = Depth;
      else if (set_count == 1) set_len = Depth + 1;
      else if (set_count == 2) set_len = Depth + 7;
      else if (roll < 70) set_len = $urandom_range(1, 8);
      else if (roll < 85) set_len = $urandom_range(9, 40);
      else set_len = $urandom_range(Depth - 8, Depth + 8);
      idle_enabled = (set_count < 6 || set_count > 11);
      for (int i = 0; i < set_len; i++) begin
        send_value(pick_value(), i == set_len - 1, 1'b0, '0);
      end
      stored_items += (set_len < Depth) ? set_len : Depth;
      set_count++;
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DrainSlack) @(negedge clk_i);
    if (error_count == 0) begin
      $display("array_sort_engine test passed");
    end else begin
      $display("array_sort_engine test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/ase_pkg.sv
sv/ase_cell.sv
sv/array_sort_engine.sv
verif/testbench.sv
